// ===== design/cmw_pkg.sv =====
package cmw_pkg;

  localparam int WIDTH     = 128;
  localparam int HEIGHT    = 128;
  localparam int MELT_STEP = 5;

  localparam int COL_W  = $clog2(WIDTH);
  localparam int OFF_W  = 9;
  localparam int ROW_W  = 7;
  localparam int CALC_W = OFF_W + 1;

  typedef logic signed [OFF_W-1:0] offset_t;
  typedef logic signed [CALC_W-1:0] calc_t;

  localparam calc_t   HEIGHT_C     = calc_t'(HEIGHT);
  localparam calc_t   STEP_C       = calc_t'(MELT_STEP);
  localparam calc_t   FAST_LIMIT   = calc_t'(16);
  localparam offset_t SEED_FLOOR   = offset_t'(-16);
  localparam offset_t SEED_RAISED  = offset_t'(-15);

  typedef enum logic [1:0] {
    REQ_SEED  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_PIXEL = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIXEL,
    ST_TICK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic             done_res;
    logic             from_new;
    logic [ROW_W-1:0] source_row;
  } result_t;

  typedef struct packed {
    offset_t next_offset;
    logic    moved;
  } melt_t;

  // byte mod 3 by summing base-4 digits
  function automatic logic [1:0] mod3_u8(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = 4'(v[7:6]) + 4'(v[5:4]) + 4'(v[3:2]) + 4'(v[1:0]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    u = (t >= 3'd3) ? t - 3'd3 : t;
    if (u == 3'd3) begin
      u = 3'd0;
    end
    return u[1:0];
  endfunction

endpackage

// ===== design/cmw_req_if.sv =====
interface cmw_req_if;
  import cmw_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [7:0]       random_byte;
  logic [3:0]       tick_count;
  logic [6:0]       column;
  logic [ROW_W-1:0] row;

  modport source (output valid, req_type, random_byte, tick_count, column, row,
                  input ready);
  modport sink (input valid, req_type, random_byte, tick_count, column, row,
                output ready);
endinterface

// ===== design/cmw_res_if.sv =====
interface cmw_res_if;
  import cmw_pkg::*;

  logic             valid;
  logic             ready;
  logic             done_res;
  logic             from_new;
  logic [ROW_W-1:0] source_row;

  modport source (output valid, done_res, from_new, source_row, input ready);
  modport sink (input valid, done_res, from_new, source_row, output ready);
endinterface

// ===== design/cmw_offset_ram.sv =====
module cmw_offset_ram #(
  parameter int DEPTH  = 128,
  parameter int DATA_W = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/cmw_col_calc.sv =====
module cmw_col_calc import cmw_pkg::*; (
  input  offset_t          cur_offset,
  input  logic [ROW_W-1:0] row,
  input  logic [7:0]       random_byte,
  input  logic             first_seed,
  input  offset_t          prev_seed,
  output melt_t            melt,
  output result_t          pixel,
  output offset_t          seed_value
);

  calc_t y;
  calc_t dy;
  calc_t sum;
  calc_t row_c;
  offset_t seed_raw;

  assign y     = calc_t'(cur_offset);
  assign row_c = calc_t'({3'b000, row});

  // one melt tick for one column
  always_comb begin
    dy   = (y < FAST_LIMIT) ? y + calc_t'(1) : STEP_C;
    sum  = y + dy;
    melt = '{next_offset: cur_offset, moved: 1'b0};
    if (y < calc_t'(0)) begin
      melt.next_offset = offset_t'(y + calc_t'(1));
      melt.moved       = 1'b1;
    end else if (y < HEIGHT_C) begin
      melt.next_offset = (sum >= HEIGHT_C) ? offset_t'(HEIGHT_C) : offset_t'(sum);
      melt.moved       = 1'b1;
    end
  end

  // pixel source
  always_comb begin
    pixel = '{done_res: 1'b0, from_new: 1'b0, source_row: row};
    if (y > calc_t'(0)) begin
      if (row_c < y) begin
        pixel.from_new = 1'b1;
      end else begin
        pixel.source_row = row - cur_offset[ROW_W-1:0];
      end
    end
  end

  // seed value
  always_comb begin
    if (first_seed) begin
      seed_raw   = -offset_t'({5'b00000, random_byte[3:0]});
      seed_value = seed_raw;
    end else begin
      seed_raw = prev_seed + offset_t'({7'b0000000, mod3_u8(random_byte)})
                 - offset_t'(1);
      if (seed_raw > offset_t'(0)) begin
        seed_value = offset_t'(0);
      end else if (seed_raw == SEED_FLOOR) begin
        seed_value = SEED_RAISED;
      end else begin
        seed_value = seed_raw;
      end
    end
  end

endmodule

// ===== design/column_melt_wipe_mapper.sv =====
// flow: seed/unused items go via the result state to the output register; a pixel item reads its
// offset first; a tick item sweeps WIDTH offsets per tick first, one per cycle, none if tick_count=0
// throughput: one item at a time; next item taken once the result sits in the output register
// reset: synchronous; after reset a clearing sweep writes zero to all WIDTH (128) offsets,
// one per cycle, while no item is taken
module column_melt_wipe_mapper import cmw_pkg::*; (
  input logic       clk,
  input logic       rst,
  cmw_req_if.sink   req,
  cmw_res_if.source res
);

  state_t state, state_next;

  logic [COL_W-1:0] col_cnt, col_cnt_next;
  logic [3:0]       ticks_left, ticks_left_next;
  logic             issue_on, issue_on_next;
  logic             wb_valid, wb_valid_next;
  logic [COL_W-1:0] wb_addr, wb_addr_next;
  logic             moved_acc, moved_acc_next;
  logic [COL_W-1:0] seed_pointer, seed_pointer_next;
  offset_t          previous_seed, previous_seed_next;
  logic [ROW_W-1:0] pix_row, pix_row_next;
  logic             pix_in_range, pix_in_range_next;
  result_t          pend, pend_next;
  result_t          out_res, out_res_next;
  logic             out_valid, out_valid_next;

  logic             we;
  logic [COL_W-1:0] waddr;
  offset_t          wdata;
  logic             re;
  logic [COL_W-1:0] raddr;
  logic [OFF_W-1:0] rdata;

  melt_t            melt;
  result_t          pixel;
  offset_t          seed_value;
  logic             out_free;
  logic             accept;

  cmw_offset_ram #(
    .DEPTH  (WIDTH),
    .DATA_W (OFF_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  cmw_col_calc u_calc (
    .cur_offset  (offset_t'(rdata)),
    .row         ((state == ST_PIXEL) ? pix_row : req.row),
    .random_byte (req.random_byte),
    .first_seed  (seed_pointer == '0),
    .prev_seed   (previous_seed),
    .melt        (melt),
    .pixel       (pixel),
    .seed_value  (seed_value)
  );

  assign out_free       = !out_valid || res.ready;
  assign req.ready      = (state == ST_IDLE);
  assign accept         = req.valid && req.ready;
  assign res.valid      = out_valid;
  assign res.done_res   = out_res.done_res;
  assign res.from_new   = out_res.from_new;
  assign res.source_row = out_res.source_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    col_cnt_next       = col_cnt;
    ticks_left_next    = ticks_left;
    issue_on_next      = issue_on;
    wb_valid_next      = 1'b0;
    wb_addr_next       = wb_addr;
    moved_acc_next     = moved_acc;
    seed_pointer_next  = seed_pointer;
    previous_seed_next = previous_seed;
    pix_row_next       = pix_row;
    pix_in_range_next  = pix_in_range;
    pend_next          = pend;
    out_res_next       = out_res;
    out_valid_next     = out_valid;
    we                 = 1'b0;
    waddr              = col_cnt;
    wdata              = offset_t'(0);
    re                 = 1'b0;
    raddr              = col_cnt;

    if (out_valid && res.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        we           = 1'b1;
        col_cnt_next = col_cnt + 1'b1;
        if (col_cnt == COL_W'(WIDTH - 1)) begin
          col_cnt_next = '0;
          state_next   = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          pend_next  = '0;
          state_next = ST_RESULT;
          case (req_type_t'(req.req_type))
            REQ_SEED: begin
              we                 = 1'b1;
              waddr              = seed_pointer;
              wdata              = seed_value;
              previous_seed_next = seed_value;
              seed_pointer_next  = (seed_pointer == COL_W'(WIDTH - 1)) ? '0
                                   : seed_pointer + 1'b1;
            end
            REQ_TICK: begin
              if (req.tick_count == 4'd0) begin
                pend_next.done_res = 1'b1;
              end else begin
                col_cnt_next    = '0;
                ticks_left_next = req.tick_count;
                issue_on_next   = 1'b1;
                moved_acc_next  = 1'b0;
                state_next      = ST_TICK;
              end
            end
            REQ_PIXEL: begin
              re                = 1'b1;
              raddr             = req.column[COL_W-1:0];
              pix_row_next      = req.row;
              pix_in_range_next = ({1'b0, req.column} < 8'(WIDTH));
              state_next        = ST_PIXEL;
            end
            default: begin
            end
          endcase
        end
      end

      ST_PIXEL: begin
        if (pix_in_range) begin
          pend_next = pixel;
        end else begin
          pend_next = '{done_res: 1'b0, from_new: 1'b0, source_row: pix_row};
        end
        state_next = ST_RESULT;
      end

      ST_TICK: begin
        if (issue_on) begin
          re            = 1'b1;
          raddr         = col_cnt;
          wb_valid_next = 1'b1;
          wb_addr_next  = col_cnt;
          col_cnt_next  = col_cnt + 1'b1;
          if (col_cnt == COL_W'(WIDTH - 1)) begin
            col_cnt_next    = '0;
            ticks_left_next = ticks_left - 4'd1;
            if (ticks_left == 4'd1) begin
              issue_on_next = 1'b0;
            end
          end
        end
        if (wb_valid) begin
          we             = 1'b1;
          waddr          = wb_addr;
          wdata          = melt.next_offset;
          moved_acc_next = moved_acc | melt.moved;
          if (!issue_on) begin
            pend_next  = '{done_res: !(moved_acc | melt.moved), from_new: 1'b0,
                           source_row: '0};
            state_next = ST_RESULT;
          end
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_res_next   = pend;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt       <= '0;
      issue_on      <= 1'b0;
      wb_valid      <= 1'b0;
      seed_pointer  <= '0;
      previous_seed <= offset_t'(0);
      out_valid     <= 1'b0;
    end else begin
      col_cnt       <= col_cnt_next;
      issue_on      <= issue_on_next;
      wb_valid      <= wb_valid_next;
      seed_pointer  <= seed_pointer_next;
      previous_seed <= previous_seed_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ticks_left   <= ticks_left_next;
    wb_addr      <= wb_addr_next;
    moved_acc    <= moved_acc_next;
    pix_row      <= pix_row_next;
    pix_in_range <= pix_in_range_next;
    pend         <= pend_next;
    out_res      <= out_res_next;
  end

endmodule

// ===== dv/tb_column_melt_wipe_mapper.sv =====
module tb_column_melt_wipe_mapper import cmw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         TOTAL_ITEMS  = 1300;
  localparam int         IDLE_LIMIT   = 20000;
  localparam int         DRAIN_CYCLES = 64;
  localparam int         FAST_ROWS    = 16;
  localparam int         LOWEST_SEED  = -15;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;

  class melt_scoreboard;
    offset_t     col_off [WIDTH];
    int unsigned seed_ptr;
    int          prev_seed;
    result_t     expected_q [$];
    int          errors;

    function new();
      foreach (col_off[i]) col_off[i] = '0;
      seed_ptr  = 0;
      prev_seed = 0;
      errors    = 0;
    endfunction

    function bit melt_finished();
      foreach (col_off[i]) begin
        if (int'(col_off[i]) < HEIGHT) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(logic [1:0] kind, logic [7:0] rnd, logic [3:0] ticks,
                            logic [6:0] col, logic [6:0] pix_row);
      result_t want;
      int      v;
      int      y;
      int      dy;
      bit      still;
      want  = '0;
      still = 1'b1;
      case (kind)
        REQ_SEED: begin
          if (seed_ptr == 0) begin
            v = -int'(rnd % 8'd16);
          end else begin
            v = prev_seed + int'(rnd % 8'd3) - 1;
            if (v > 0) begin
              v = 0;
            end else if (v == LOWEST_SEED - 1) begin
              v = LOWEST_SEED;
            end
          end
          col_off[seed_ptr] = offset_t'(v);
          prev_seed = v;
          seed_ptr = (seed_ptr + 1 >= WIDTH) ? 0 : seed_ptr + 1;
        end
        REQ_TICK: begin
          for (int t = 0; t < int'(ticks); t++) begin
            for (int i = 0; i < WIDTH; i++) begin
              y = int'(col_off[i]);
              if (y < 0) begin
                col_off[i] = offset_t'(y + 1);
                still = 1'b0;
              end else if (y < HEIGHT) begin
                dy = (y < FAST_ROWS) ? y + 1 : MELT_STEP;
                if (y + dy >= HEIGHT) dy = HEIGHT - y;
                col_off[i] = offset_t'(y + dy);
                still = 1'b0;
              end
            end
          end
          want.done_res = still;
        end
        REQ_PIXEL: begin
          if (int'(col) < WIDTH) begin
            y = int'(col_off[col]);
            if (y > 0 && int'(pix_row) < y) begin
              want.from_new   = 1'b1;
              want.source_row = pix_row;
            end else if (y > 0) begin
              v = int'(pix_row) - y;
              want.source_row = v[6:0];
            end else begin
              want.source_row = pix_row;
            end
          end else begin
            want.source_row = pix_row;
          end
        end
        default: ;
      endcase
      expected_q.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result done_res=%0d from_new=%0d source_row=%0d",
                 $time, got.done_res, got.from_new, got.source_row);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.done_res !== want.done_res) begin
        $display("%0t: done_res expected %0d actual %0d", $time, want.done_res, got.done_res);
        errors++;
      end
      if (got.from_new !== want.from_new) begin
        $display("%0t: from_new expected %0d actual %0d", $time, want.from_new, got.from_new);
        errors++;
      end
      if (got.source_row !== want.source_row) begin
        $display("%0t: source_row expected %0d actual %0d", $time, want.source_row,
                 got.source_row);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  cmw_req_if req_bus ();
  cmw_res_if res_bus ();

  column_melt_wipe_mapper u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus.sink),
    .res (res_bus.source)
  );

  melt_scoreboard sb = new();

  int      items_sent    = 0;
  int      send_idle_pct = 0;
  int      stall_pct     = 0;
  int      idle_cycles   = 0;
  result_t seen_res;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_bus.valid && res_bus.ready) begin
        seen_res.done_res   = res_bus.done_res;
        seen_res.from_new   = res_bus.from_new;
        seen_res.source_row = res_bus.source_row;
        sb.check_result(seen_res);
      end
      if (req_bus.valid && req_bus.ready) begin
        sb.note_item(req_bus.req_type, req_bus.random_byte, req_bus.tick_count,
                     req_bus.column, req_bus.row);
      end
    end
    if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] rnd,
                           input logic [3:0] ticks, input logic [6:0] col,
                           input logic [6:0] pix_row);
    case (items_sent * 4 / TOTAL_ITEMS)
      0: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      1: begin
        send_idle_pct = 70;
        stall_pct     = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct     = 70;
      end
      default: begin
        send_idle_pct = 19;
        stall_pct     = 19;
      end
    endcase
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= kind;
    req_bus.random_byte <= rnd;
    req_bus.tick_count  <= ticks;
    req_bus.column      <= col;
    req_bus.row         <= pix_row;
    @(posedge clk);
    while (!(req_bus.valid && req_bus.ready)) @(posedge clk);
    @(negedge clk);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  task automatic send_pixel(input logic [6:0] col, input logic [6:0] pix_row);
    send_item(REQ_PIXEL, 8'($urandom), 4'($urandom), col, pix_row);
  endtask

  task automatic send_tick(input logic [3:0] ticks);
    send_item(REQ_TICK, 8'($urandom), ticks, 7'($urandom), 7'($urandom));
  endtask

  task automatic send_seed(input logic [7:0] rnd);
    send_item(REQ_SEED, rnd, 4'($urandom), 7'($urandom), 7'($urandom));
  endtask

  function automatic logic [3:0] pick_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 4'($urandom_range(1, 3));
    if (r < 88) return 4'($urandom_range(4, 7));
    return 4'($urandom_range(8, 15));
  endfunction

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0) begin
      send_pixel(7'($urandom), 7'($urandom));
    end else begin
      send_item(REQ_UNUSED, 8'($urandom), 4'($urandom), 7'($urandom), 7'($urandom));
    end
  endtask

  // seed a run of columns, then melt to the end with pixel lookups in between
  task automatic run_melt_episode();
    int n_seed;
    int guard;
    n_seed = ($urandom_range(0, 99) < 85) ? WIDTH : $urandom_range(1, WIDTH - 1);
    for (int i = 0; i < n_seed; i++) begin
      if ($urandom_range(0, 99) < 6) send_noise();
      send_seed(8'($urandom));
    end
    guard = 0;
    while (!sb.melt_finished() && guard < 400) begin
      send_tick(pick_ticks());
      repeat ($urandom_range(0, 6)) send_pixel(7'($urandom), 7'($urandom));
      if ($urandom_range(0, 99) < 3) send_noise();
      guard++;
    end
    send_tick(4'($urandom_range(0, 15)));
    repeat ($urandom_range(0, 4)) send_pixel(7'($urandom), 7'($urandom));
  endtask

  initial begin
    rst                 = 1'b1;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = REQ_SEED;
    req_bus.random_byte = '0;
    req_bus.tick_count  = '0;
    req_bus.column      = '0;
    req_bus.row         = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_pixel(7'd0, 7'd0);
    send_pixel(7'd127, 7'd127);
    send_item(REQ_UNUSED, 8'hff, 4'hf, 7'h7f, 7'h7f);
    send_tick(4'd0);
    send_seed(8'd255);
    send_seed(8'd0);
    send_seed(8'd2);
    send_seed(8'd128);
    send_tick(4'd1);
    send_pixel(7'd3, 7'd0);
    send_pixel(7'd3, 7'd1);
    send_pixel(7'd0, 7'd127);
    send_tick(4'd8);
    send_pixel(7'd64, 7'd50);
    send_pixel(7'd64, 7'd127);
    send_tick(4'd15);
    send_pixel(7'd1, 7'd20);
    send_tick(4'd15);
    send_tick(4'd15);
    send_tick(4'd15);
    send_tick(4'd0);
    send_pixel(7'd127, 7'd0);
    send_pixel(7'd5, 7'd127);

    while (items_sent < TOTAL_ITEMS) run_melt_episode();

    req_bus.valid <= 1'b0;
    stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
